// ----- rtl/core/scruf_pkg.sv -----
// Package for the consecutive-run union-find unit: sizes, slot types and
// the item record passed from the front end to the back end. No dependencies.
`default_nettype none
package scruf_pkg;
  localparam int Capacity = 256;
  localparam int SlotW = $clog2(Capacity);
  localparam int CountW = $clog2(Capacity + 1);
  localparam int RunW = 9;
  localparam logic [RunW-1:0] RunMax = 9'd511;

  typedef logic [SlotW-1:0] slot_t;
  typedef logic [CountW-1:0] count_t;

  // One classified word from the front end.
  typedef struct packed {
    logic [31:0] value;
    logic        dup;
    logic        drop;
  } item_t;
endpackage
`default_nettype wire

// ----- rtl/core/scruf_front.sv -----
// Front end: takes input words, scans the value store for a duplicate and
// writes new values into free slots. Uses scruf_pkg.
`default_nettype none
module scruf_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [31:0]          value,
  output logic                      q_valid,
  input  wire logic                 q_ready,
  output scruf_pkg::item_t          q_item
);
  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_SCAN = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t           state;
  scruf_pkg::count_t slot_count;
  logic [31:0]       cur;
  scruf_pkg::count_t idx;
  logic              found;
  logic [31:0]       mem [scruf_pkg::Capacity];
  logic [31:0]       rd;
  logic              rd_ok;

  assign in_ready = (state == F_IDLE);
  assign q_valid  = (state == F_PUSH);

  // Store read registered; one entry compared per cycle.
  always_ff @(posedge clk) begin
    rd <= mem[idx[scruf_pkg::SlotW-1:0]];
    if (state == F_PUSH && q_ready && !found &&
        slot_count != scruf_pkg::CountW'(scruf_pkg::Capacity)) begin
      mem[slot_count[scruf_pkg::SlotW-1:0]] <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= F_IDLE;
      slot_count <= '0;
      rd_ok      <= 1'b0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (in_valid) begin
            cur   <= value;
            idx   <= '0;
            found <= 1'b0;
            rd_ok <= 1'b0;
            state <= (slot_count == '0) ? F_PUSH : F_SCAN;
          end
        end
        F_SCAN: begin
          if (rd_ok && rd == cur) begin
            found <= 1'b1;
            state <= F_PUSH;
          end else if (rd_ok && idx == slot_count) begin
            state <= F_PUSH;
          end else begin
            idx   <= idx + 1'b1;
            rd_ok <= 1'b1;
          end
        end
        F_PUSH: begin
          if (q_ready) begin
            state <= F_IDLE;
            if (!found && slot_count != scruf_pkg::CountW'(scruf_pkg::Capacity)) begin
              slot_count <= slot_count + 1'b1;
            end
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  assign q_item.value = cur;
  assign q_item.dup   = found;
  assign q_item.drop  = !found && (slot_count == scruf_pkg::CountW'(scruf_pkg::Capacity));
endmodule
`default_nettype wire

// ----- rtl/core/scruf_back.sv -----
// Back end: keeps its own copy of values, neighbor lookups, find with path
// halving, and union by size; produces the result word. Uses scruf_pkg.
`default_nettype none
module scruf_back (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      q_valid,
  output logic                           q_ready,
  input  wire scruf_pkg::item_t          q_item,
  input  wire logic                      out_ready,
  output logic                           out_valid,
  output logic [scruf_pkg::RunW-1:0]     longest_run,
  output logic                           was_duplicate,
  output logic                           was_dropped
);
  typedef enum logic [9:0] {
    B_IDLE = 10'b0000000001,
    B_SCAN = 10'b0000000010,
    B_FIND = 10'b0000000100,
    B_FP1  = 10'b0000001000,
    B_FP2  = 10'b0000010000,
    B_SZRD = 10'b0000100000,
    B_SZ   = 10'b0001000000,
    B_LINK = 10'b0010000000,
    B_NEXT = 10'b0100000000,
    B_OUT  = 10'b1000000000
  } bstate_t;

  bstate_t                      state;
  logic [31:0]                  vals [scruf_pkg::Capacity];
  scruf_pkg::slot_t             par  [scruf_pkg::Capacity];
  logic [scruf_pkg::RunW-1:0]   sz   [scruf_pkg::Capacity];
  scruf_pkg::count_t            count;
  scruf_pkg::slot_t             s;
  logic [31:0]                  key;
  logic                         pass;    // 0: value-1, 1: value+1
  logic                         skip;
  scruf_pkg::count_t            idx;
  scruf_pkg::count_t            idx_prev;
  logic                         rd_ok;
  scruf_pkg::slot_t             hit;
  scruf_pkg::slot_t             ra, rb, cur;
  scruf_pkg::slot_t             paddr;
  logic [31:0]                  rd_val;
  scruf_pkg::slot_t             rd_par;
  logic [scruf_pkg::RunW-1:0]   rd_sa, rd_sb;
  logic [scruf_pkg::RunW-1:0]   best;
  logic [scruf_pkg::RunW:0]     sum;
  logic                         walk_b;
  logic [31:0]                  v;
  logic                         new_word;

  assign q_ready = (state == B_IDLE);
  assign out_valid = (state == B_OUT);
  assign longest_run = best;
  assign idx_prev = idx - 1'b1;
  assign new_word = q_valid && !q_item.dup && !q_item.drop;
  // During a find the next parent read follows the parent just read.
  assign paddr = (state == B_FP1 || state == B_FP2) ? rd_par : cur;
  assign sum = {1'b0, rd_sa} + {1'b0, rd_sb};

  // All store reads are registered; the FSM sees the data in the cycle after the address.
  always_ff @(posedge clk) begin
    rd_val <= vals[idx[scruf_pkg::SlotW-1:0]];
    rd_par <= par[paddr];
    rd_sa  <= sz[ra];
    rd_sb  <= sz[rb];
    if (state == B_IDLE && new_word) begin
      vals[count[scruf_pkg::SlotW-1:0]] <= q_item.value;
      par[count[scruf_pkg::SlotW-1:0]]  <= count[scruf_pkg::SlotW-1:0];
      sz[count[scruf_pkg::SlotW-1:0]]   <= 9'd1;
    end
    if (state == B_FP2) begin
      par[cur] <= rd_par;
    end
    if (state == B_LINK) begin
      par[rb] <= ra;
      sz[ra]  <= sum[scruf_pkg::RunW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      count <= '0;
      best  <= '0;
      was_duplicate <= 1'b0;
      was_dropped   <= 1'b0;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (q_valid) begin
            v             <= q_item.value;
            was_duplicate <= q_item.dup;
            was_dropped   <= q_item.drop;
            if (!new_word) begin
              state <= B_OUT;
            end else begin
              s <= count[scruf_pkg::SlotW-1:0];
              count <= count + 1'b1;
              if (best == '0) best <= 9'd1;
              pass   <= 1'b0;
              key    <= q_item.value - 32'd1;
              skip   <= (q_item.value == 32'h8000_0000);
              idx    <= '0;
              rd_ok  <= 1'b0;
              state  <= B_SCAN;
            end
          end
        end
        B_SCAN: begin
          // Linear search of stored slots; rd_val holds the entry at idx - 1.
          if (skip) begin
            state <= B_NEXT;
          end else if (rd_ok && rd_val == key) begin
            hit    <= idx_prev[scruf_pkg::SlotW-1:0];
            cur    <= s;
            walk_b <= 1'b0;
            state  <= B_FIND;
          end else if (rd_ok && idx == count) begin
            state <= B_NEXT;
          end else begin
            idx   <= idx + 1'b1;
            rd_ok <= 1'b1;
          end
        end
        B_FIND: begin
          state <= B_FP1;
        end
        B_FP1: begin
          // rd_par is the parent of cur.
          if (rd_par == cur) begin
            if (!walk_b) begin
              ra     <= cur;
              cur    <= hit;
              walk_b <= 1'b1;
              state  <= B_FIND;
            end else begin
              rb    <= cur;
              state <= B_SZRD;
            end
          end else begin
            state <= B_FP2;
          end
        end
        B_FP2: begin
          // Path halving step: cur now points at its grandparent.
          cur   <= rd_par;
          state <= B_FP1;
        end
        B_SZRD: begin
          state <= B_SZ;
        end
        B_SZ: begin
          if (ra == rb) begin
            state <= B_NEXT;
          end else begin
            if (rd_sa < rd_sb) begin
              ra <= rb;
              rb <= ra;
            end
            state <= B_LINK;
          end
        end
        B_LINK: begin
          if (sum[scruf_pkg::RunW-1:0] > best) best <= sum[scruf_pkg::RunW-1:0];
          state <= B_NEXT;
        end
        B_NEXT: begin
          if (!pass) begin
            pass   <= 1'b1;
            key    <= v + 32'd1;
            skip   <= (v == 32'h7FFF_FFFF);
            idx    <= '0;
            rd_ok  <= 1'b0;
            state  <= B_SCAN;
          end else begin
            state <= B_OUT;
          end
        end
        B_OUT: begin
          if (out_ready) state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/streaming_consecutive_run_union_find_unit.sv -----
// Top level of the consecutive-run union-find unit.
// Instantiates scruf_front and scruf_back; uses scruf_pkg.
//
// Usage: in_valid/in_ready carry one signed 32-bit value word. out_valid/
// out_ready carry one result word per input: longest_run, was_duplicate and
// was_dropped. The front end classifies a word against its stored values
// (one store entry compared per cycle) and hands it to the back end. For a
// new value the back end scans its store twice, for value-1 and value+1,
// and runs find with path halving and union by size. A duplicate or dropped
// word goes straight to the result. The back end's store scans set the rate
// for new values. The front end accepts the next word while the back end
// works. Reset clears slot counts and the best run; stored entries are left
// as they are. When out_ready is low the result is held and both parts stall
// in turn.
`default_nettype none
module streaming_consecutive_run_union_find_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [8:0]       longest_run,
  output logic             was_duplicate,
  output logic             was_dropped
);
  logic              q_valid, q_ready;
  scruf_pkg::item_t  q_item;

  scruf_front u_front (
    .clk, .rst, .in_valid, .in_ready, .value,
    .q_valid, .q_ready, .q_item
  );

  scruf_back u_back (
    .clk, .rst, .q_valid, .q_ready, .q_item,
    .out_ready, .out_valid, .longest_run, .was_duplicate, .was_dropped
  );
endmodule
`default_nettype wire
